>>> design/assert_macros.svh
// assertion macros used by the rasterizer back end
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, sampled on clk, off during reset
`define MCR_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication, sampled on clk, off during reset
`define MCR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define MCR_ASSERT_IMPL(label, ante, cons)
`define MCR_ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> design/mcr_pkg.sv
// types, command codes and octant table for the midpoint circle rasterizer
`default_nettype none
package mcr_pkg;

    localparam int CMD_BITS   = 2;
    localparam int THICK_BITS = 8;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_OUTLINE = 2'd0,
        CMD_FILL    = 2'd1,
        CMD_STEP    = 2'd2
    } cmd_t;

    // per-iteration flags carried from front to back
    typedef struct packed {
        logic fill;
        logic ink;
        logic done;
    } step_flags_t;

    // how one result is formed from the walk point
    typedef struct packed {
        logic swap;
        logic neg_x;
        logic neg_y;
    } oct_t;

    function automatic oct_t oct_sel(input logic fill, input logic [2:0] k);
        oct_t o;
        if (fill)
        begin
            o.swap  = k[0];
            o.neg_x = 1'b1;
            o.neg_y = k[1];
        end
        else
        begin
            case (k)
                3'd0:    o = '{swap: 1'b0, neg_x: 1'b0, neg_y: 1'b0};
                3'd1:    o = '{swap: 1'b1, neg_x: 1'b0, neg_y: 1'b0};
                3'd2:    o = '{swap: 1'b1, neg_x: 1'b1, neg_y: 1'b0};
                3'd3:    o = '{swap: 1'b0, neg_x: 1'b1, neg_y: 1'b0};
                3'd4:    o = '{swap: 1'b0, neg_x: 1'b1, neg_y: 1'b1};
                3'd5:    o = '{swap: 1'b1, neg_x: 1'b1, neg_y: 1'b1};
                3'd6:    o = '{swap: 1'b1, neg_x: 1'b0, neg_y: 1'b1};
                default: o = '{swap: 1'b0, neg_x: 1'b0, neg_y: 1'b1};
            endcase
        end
        return o;
    endfunction

endpackage
`default_nettype wire

>>> design/mcr_front.sv
// command decode and midpoint walk, one iteration descriptor per step
`default_nettype none
module mcr_front #(
    parameter int COORD_BITS  = 12,
    parameter int RADIUS_BITS = 10
) (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                in_valid,
    output logic                               in_ready,
    input  wire  [mcr_pkg::CMD_BITS-1:0]       cmd,
    input  wire  [COORD_BITS-1:0]              center_x,
    input  wire  [COORD_BITS-1:0]              center_y,
    input  wire  [RADIUS_BITS-1:0]             radius,
    input  wire  [mcr_pkg::THICK_BITS-1:0]     thickness,
    input  wire                                ink,
    input  wire                                q_full,
    output logic                               push,
    output logic [COORD_BITS-1:0]              push_cx,
    output logic [COORD_BITS-1:0]              push_cy,
    output logic [RADIUS_BITS:0]               push_x,
    output logic [RADIUS_BITS:0]               push_y,
    output mcr_pkg::step_flags_t               push_flags
);
    import mcr_pkg::*;

    localparam int C  = COORD_BITS;
    localparam int R  = RADIUS_BITS;
    localparam int DW = R + 4;
    localparam int EW = DW + 1;
    localparam int IW = ((R > THICK_BITS) ? R : THICK_BITS) + 1;

    logic                    busy_reg, busy_next;
    logic                    fill_reg, fill_next;
    logic                    ink_reg, ink_next;
    logic [C-1:0]            cx_reg, cx_next;
    logic [C-1:0]            cy_reg, cy_next;
    logic [R-1:0]            rad_reg, rad_next;
    logic [THICK_BITS-1:0]   rings_reg, rings_next;
    logic [THICK_BITS-1:0]   idx_reg, idx_next;
    logic signed [R:0]       x_reg, x_next;
    logic signed [R:0]       y_reg, y_next;
    logic signed [DW-1:0]    d_reg, d_next;

    logic                    accept;
    logic                    d_neg;
    logic signed [R:0]       x_step;
    logic signed [R:0]       y_step;
    logic [EW-1:0]           x_ext, y_ext, d_ext, d_inc, d_sum;
    logic                    ring_end;
    logic [IW-1:0]           idx_inc;
    logic                    rings_out;
    logic                    shape_end;
    logic [R-1:0]            next_rad;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    // one walk iteration from the current point
    always_comb
    begin
        d_neg   = d_reg[DW-1];
        x_step  = d_neg ? x_reg : x_reg - (R+1)'(1);
        y_step  = y_reg + (R+1)'(1);
        x_ext   = {{(EW-R-1){x_step[R]}}, x_step};
        y_ext   = {{(EW-R-1){y_reg[R]}}, y_reg};
        d_ext   = {d_reg[DW-1], d_reg};
        d_inc   = d_neg ? ((y_ext << 2) + EW'(6)) : (((y_ext - x_ext) << 2) + EW'(10));
        d_sum   = d_ext + d_inc;
        ring_end  = x_step < y_step;
        idx_inc   = IW'(idx_reg) + IW'(1);
        rings_out = (idx_inc >= IW'(rings_reg)) || (idx_inc > IW'(rad_reg));
        shape_end = ring_end && (fill_reg || rings_out);
        next_rad  = rad_reg - idx_inc[R-1:0];
    end

    always_comb
    begin
        busy_next  = busy_reg;
        fill_next  = fill_reg;
        ink_next   = ink_reg;
        cx_next    = cx_reg;
        cy_next    = cy_reg;
        rad_next   = rad_reg;
        rings_next = rings_reg;
        idx_next   = idx_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        d_next     = d_reg;
        push       = 1'b0;
        if (accept)
        begin
            case (cmd)
                CMD_OUTLINE, CMD_FILL:
                begin
                    fill_next  = (cmd == CMD_FILL);
                    ink_next   = ink;
                    cx_next    = center_x;
                    cy_next    = center_y;
                    rad_next   = radius;
                    rings_next = thickness;
                    idx_next   = '0;
                    x_next     = (R+1)'(radius);
                    y_next     = '0;
                    d_next     = DW'(3) - (DW'(radius) << 1);
                    busy_next  = (cmd == CMD_FILL) || (thickness != '0);
                end
                CMD_STEP:
                begin
                    if (busy_reg)
                    begin
                        push   = 1'b1;
                        x_next = x_step;
                        y_next = y_step;
                        d_next = d_sum[DW-1:0];
                        if (shape_end)
                        begin
                            busy_next = 1'b0;
                        end
                        else if (ring_end)
                        begin
                            // next concentric ring, one pixel smaller
                            idx_next = idx_inc[THICK_BITS-1:0];
                            x_next   = (R+1)'(next_rad);
                            y_next   = '0;
                            d_next   = DW'(3) - (DW'(next_rad) << 1);
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign push_cx          = cx_reg;
    assign push_cy          = cy_reg;
    assign push_x           = x_reg;
    assign push_y           = y_reg;
    assign push_flags.fill  = fill_reg;
    assign push_flags.ink   = ink_reg;
    assign push_flags.done  = shape_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            fill_reg  <= 1'b0;
            ink_reg   <= 1'b0;
            cx_reg    <= '0;
            cy_reg    <= '0;
            rad_reg   <= '0;
            rings_reg <= '0;
            idx_reg   <= '0;
            x_reg     <= '0;
            y_reg     <= '0;
            d_reg     <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            fill_reg  <= fill_next;
            ink_reg   <= ink_next;
            cx_reg    <= cx_next;
            cy_reg    <= cy_next;
            rad_reg   <= rad_next;
            rings_reg <= rings_next;
            idx_reg   <= idx_next;
            x_reg     <= x_next;
            y_reg     <= y_next;
            d_reg     <= d_next;
        end
    end

endmodule
`default_nettype wire

>>> design/mcr_queue.sv
// small fifo of iteration descriptors between front and back
`default_nettype none
module mcr_queue #(
    parameter int WIDTH = 50,
    parameter int DEPTH = 2
) (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              push,
    input  wire  [WIDTH-1:0] push_data,
    input  wire              pop,
    output logic             full,
    output logic             head_valid,
    output logic [WIDTH-1:0] head_data
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_reg, wr_next;
    logic [PW-1:0]    rd_reg, rd_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full       = (cnt_reg == CW'(DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_data  = mem_reg[rd_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (do_push)
        begin
            wr_next = (wr_reg == PW'(DEPTH - 1)) ? '0 : wr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_next = (rd_reg == PW'(DEPTH - 1)) ? '0 : rd_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule
`default_nettype wire

>>> design/mcr_back.sv
// expands one iteration into its pixels or spans, one result per cycle while out_ready is high and a descriptor waits
`default_nettype none
`include "assert_macros.svh"
module mcr_back #(
    parameter int COORD_BITS  = 12,
    parameter int RADIUS_BITS = 10
) (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      head_valid,
    input  wire  [COORD_BITS-1:0]    head_cx,
    input  wire  [COORD_BITS-1:0]    head_cy,
    input  wire  [RADIUS_BITS:0]     head_x,
    input  wire  [RADIUS_BITS:0]     head_y,
    input  wire mcr_pkg::step_flags_t head_flags,
    output logic                     pop,
    output logic                     out_valid,
    input  wire                      out_ready,
    output logic [COORD_BITS:0]      x_start,
    output logic [COORD_BITS:0]      y_start,
    output logic [COORD_BITS:0]      x_end,
    output logic [COORD_BITS:0]      y_end,
    output logic                     pixel_ink,
    output logic                     last_of_step,
    output logic                     shape_done
);
    import mcr_pkg::*;

    localparam int C  = COORD_BITS;
    localparam int R  = RADIUS_BITS;
    localparam int SW = ((C > R + 1) ? C : R + 1) + 1;

    logic [2:0]    k_reg, k_next;
    logic          valid_reg, valid_next;
    logic [C:0]    xs_reg, ys_reg, xe_reg, ye_reg;
    logic          ink_reg, last_reg, done_reg;

    oct_t          sel;
    logic          load;
    logic          is_last;
    logic [R:0]    a_val, b_val;
    logic [SW-1:0] x0_ext, y0_ext, a_ext, b_ext;
    logic [SW-1:0] xs_sum, xe_sum, ys_sum;

    always_comb
    begin
        sel     = oct_sel(head_flags.fill, k_reg);
        is_last = head_flags.fill ? (k_reg == 3'd3) : (k_reg == 3'd7);
        a_val   = sel.swap ? head_y : head_x;
        b_val   = sel.swap ? head_x : head_y;
        x0_ext  = {{(SW-C){head_cx[C-1]}}, head_cx};
        y0_ext  = {{(SW-C){head_cy[C-1]}}, head_cy};
        a_ext   = {{(SW-R-1){a_val[R]}}, a_val};
        b_ext   = {{(SW-R-1){b_val[R]}}, b_val};
        xs_sum  = sel.neg_x ? x0_ext - a_ext : x0_ext + a_ext;
        // a span runs to the mirrored end, a pixel ends where it starts
        xe_sum  = head_flags.fill ? x0_ext + a_ext : xs_sum;
        ys_sum  = sel.neg_y ? y0_ext - b_ext : y0_ext + b_ext;
    end

    assign load = head_valid && (!valid_reg || out_ready);
    assign pop  = load && is_last;

    always_comb
    begin
        k_next     = k_reg;
        valid_next = valid_reg;
        if (valid_reg && out_ready)
        begin
            valid_next = 1'b0;
        end
        if (load)
        begin
            valid_next = 1'b1;
            k_next     = is_last ? 3'd0 : k_reg + 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            xs_reg   <= xs_sum[C:0];
            ys_reg   <= ys_sum[C:0];
            xe_reg   <= xe_sum[C:0];
            ye_reg   <= ys_sum[C:0];
            ink_reg  <= head_flags.ink;
            last_reg <= is_last;
            done_reg <= is_last && head_flags.done;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg     <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            k_reg     <= k_next;
            valid_reg <= valid_next;
        end
    end

    assign out_valid    = valid_reg;
    assign x_start      = xs_reg;
    assign y_start      = ys_reg;
    assign x_end        = xe_reg;
    assign y_end        = ye_reg;
    assign pixel_ink    = ink_reg;
    assign last_of_step = last_reg;
    assign shape_done   = done_reg;

    `MCR_ASSERT_IMPL(a_done_is_last, valid_reg && done_reg, last_reg)
    `MCR_ASSERT_IMPL(a_fill_four, head_valid && head_flags.fill, k_reg < 3'd4)
    `MCR_ASSERT_NEXT(a_stall_holds_k, valid_reg && !out_ready, k_reg == $past(k_reg))

endmodule
`default_nettype wire

>>> design/midpoint_circle_rasterizer.sv
// a step's descriptor is queued on its transaction, its results registered from the queue head
// throughput: one result per cycle while m_tready is high and a descriptor waits;
// eight results a step outline, four filled; the back end forms one pixel or span per cycle
// a two-entry descriptor queue lets the walk run up to two steps ahead
// reset: asynchronous, active low; clears walk state, queue pointers and output valid, block idle
`default_nettype none
module midpoint_circle_rasterizer #(
    parameter int COORD_BITS  = 12,
    parameter int RADIUS_BITS = 10
) (
    input  wire  clk,
    input  wire  rst_n,
    input  wire  s_tvalid,
    output logic s_tready,
    // center_x, center_y, radius, thickness, ink, zero pad
    input  wire  [((2*COORD_BITS+RADIUS_BITS+mcr_pkg::THICK_BITS+1+7)/8)*8-1:0] s_tdata,
    // cmd
    input  wire  [mcr_pkg::CMD_BITS-1:0] s_tuser,
    output logic m_tvalid,
    input  wire  m_tready,
    // x_start, y_start, x_end, y_end, pixel_ink, zero pad
    output logic [((4*(COORD_BITS+1)+1+7)/8)*8-1:0] m_tdata,
    output logic m_tlast,
    // shape_done
    output logic m_tuser
);
    import mcr_pkg::*;

    localparam int C     = COORD_BITS;
    localparam int R     = RADIUS_BITS;
    localparam int OUT_W = ((4*(C+1)+1+7)/8)*8;
    localparam int PAD_W = OUT_W - 4*(C+1) - 1;
    localparam int QW    = 2*C + 2*(R+1) + $bits(step_flags_t);

    logic                q_full, q_push, q_pop, q_head_valid;
    logic [C-1:0]        push_cx, push_cy;
    logic [R:0]          push_x, push_y;
    step_flags_t         push_flags;
    logic [QW-1:0]       q_head;
    logic [C-1:0]        head_cx, head_cy;
    logic [R:0]          head_x, head_y;
    step_flags_t         head_flags;
    logic [C:0]          xs, ys, xe, ye;
    logic                p_ink;

    mcr_front #(
        .COORD_BITS  (C),
        .RADIUS_BITS (R)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .cmd        (s_tuser),
        .center_x   (s_tdata[C-1:0]),
        .center_y   (s_tdata[2*C-1:C]),
        .radius     (s_tdata[2*C+R-1:2*C]),
        .thickness  (s_tdata[2*C+R+THICK_BITS-1:2*C+R]),
        .ink        (s_tdata[2*C+R+THICK_BITS]),
        .q_full     (q_full),
        .push       (q_push),
        .push_cx    (push_cx),
        .push_cy    (push_cy),
        .push_x     (push_x),
        .push_y     (push_y),
        .push_flags (push_flags)
    );

    mcr_queue #(
        .WIDTH (QW),
        .DEPTH (2)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  ({push_flags, push_y, push_x, push_cy, push_cx}),
        .pop        (q_pop),
        .full       (q_full),
        .head_valid (q_head_valid),
        .head_data  (q_head)
    );

    assign {head_flags, head_y, head_x, head_cy, head_cx} = q_head;

    mcr_back #(
        .COORD_BITS  (C),
        .RADIUS_BITS (R)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (q_head_valid),
        .head_cx      (head_cx),
        .head_cy      (head_cy),
        .head_x       (head_x),
        .head_y       (head_y),
        .head_flags   (head_flags),
        .pop          (q_pop),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .x_start      (xs),
        .y_start      (ys),
        .x_end        (xe),
        .y_end        (ye),
        .pixel_ink    (p_ink),
        .last_of_step (m_tlast),
        .shape_done   (m_tuser)
    );

    assign m_tdata = {{PAD_W{1'b0}}, p_ink, ye, xe, ys, xs};

endmodule
`default_nettype wire

>>> tb/sv/midpoint_circle_rasterizer_tb.sv
// self-checking testbench for the midpoint circle rasterizer: directed table, then random shapes
`timescale 1ns / 1ps
module midpoint_circle_rasterizer_tb;

    localparam int IN_W       = 48;
    localparam int OUT_W      = 56;
    localparam int IDLE_LIMIT = 4000;
    localparam int HOLD_OFF   = 300;
    localparam int HOLD_AT    = 150;
    localparam int WORK_ITEMS = 130;
    localparam logic [1:0] CMD_RSVD = 2'd3;

    // one pixel or span as it leaves the block
    typedef struct packed {
        logic signed [12:0] xs;
        logic signed [12:0] ys;
        logic signed [12:0] xe;
        logic signed [12:0] ye;
        logic               ink;
        logic               last;
        logic               done;
    } span_t;

    typedef struct {
        logic [1:0] cmd;
        int         cx;
        int         cy;
        int         rad;
        int         thick;
        bit         ink;
        bit         typed;     // expectation written in the row, not predicted
        int         n_typed;   // results, all at the centre
        bit         done_typed;
    } plan_row_t;

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata;
    logic [1:0]        s_tuser;
    logic              m_tvalid;
    logic              m_tready;
    logic [OUT_W-1:0]  m_tdata;
    logic              m_tlast;
    logic              m_tuser;

    midpoint_circle_rasterizer dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // predicted walk state
    bit  w_busy;
    bit  w_fill;
    int  w_ccol;
    int  w_crow;
    int  w_orad;
    int  w_rings;
    int  w_ring;
    int  w_x;
    int  w_y;
    int  w_dec;
    bit  w_ink;

    span_t iter_out [8];
    span_t pending_spans [$];
    plan_row_t plan [$];

    int errors;
    int sent_count;
    int rx_count;
    int work_count;
    int idle_cycles;

    function automatic span_t make_span(int xs, int ys, int xe, int ye);
        span_t s;
        s.xs   = xs[12:0];
        s.ys   = ys[12:0];
        s.xe   = xe[12:0];
        s.ye   = ye[12:0];
        s.ink  = w_ink;
        s.last = 1'b0;
        s.done = 1'b0;
        return s;
    endfunction

    function automatic logic [IN_W-1:0] pack_shape(int cx, int cy, int rad, int thick, bit ink);
        logic [IN_W-1:0] d;
        d        = '0;
        d[11:0]  = cx[11:0];
        d[23:12] = cy[11:0];
        d[33:24] = rad[9:0];
        d[41:34] = thick[7:0];
        d[42]    = ink;
        return d;
    endfunction

    task automatic prime_walk(input int r);
        w_x   = r;
        w_y   = 0;
        w_dec = 3 - 2 * r;
    endtask

    // one command through the circle walk; fills iter_out with n results
    task automatic walk_circle(input logic [1:0] cmd, input logic [IN_W-1:0] d, output int n);
        int  x;
        int  y;
        int  c;
        int  r;
        bit  fin;
        n   = 0;
        fin = 1'b0;
        if (cmd == mcr_pkg::CMD_OUTLINE || cmd == mcr_pkg::CMD_FILL)
        begin
            w_fill  = (cmd == mcr_pkg::CMD_FILL);
            w_ccol  = $signed(d[11:0]);
            w_crow  = $signed(d[23:12]);
            w_orad  = d[33:24];
            w_rings = d[41:34];
            w_ink   = d[42];
            w_ring  = 0;
            prime_walk(w_orad);
            w_busy  = w_fill || w_rings != 0;
            return;
        end
        if (cmd != mcr_pkg::CMD_STEP || !w_busy)
            return;
        c = w_ccol;
        r = w_crow;
        x = w_x;
        y = w_y;
        if (w_fill)
        begin
            iter_out[0] = make_span(c - x, r + y, c + x, r + y);
            iter_out[1] = make_span(c - y, r + x, c + y, r + x);
            iter_out[2] = make_span(c - x, r - y, c + x, r - y);
            iter_out[3] = make_span(c - y, r - x, c + y, r - x);
            n = 4;
        end
        else
        begin
            iter_out[0] = make_span(c + x, r + y, c + x, r + y);
            iter_out[1] = make_span(c + y, r + x, c + y, r + x);
            iter_out[2] = make_span(c - y, r + x, c - y, r + x);
            iter_out[3] = make_span(c - x, r + y, c - x, r + y);
            iter_out[4] = make_span(c - x, r - y, c - x, r - y);
            iter_out[5] = make_span(c - y, r - x, c - y, r - x);
            iter_out[6] = make_span(c + y, r - x, c + y, r - x);
            iter_out[7] = make_span(c + x, r - y, c + x, r - y);
            n = 8;
        end
        if (w_dec >= 0)
        begin
            x     = x - 1;
            w_dec = w_dec + 4 * (y - x) + 10;
        end
        else
            w_dec = w_dec + 4 * y + 6;
        y   = y + 1;
        w_x = x;
        w_y = y;
        if (x < y)
        begin
            if (w_fill)
                fin = 1'b1;
            else
            begin
                w_ring = w_ring + 1;
                // ring count reached, or the next ring radius would go negative
                if (w_ring >= w_rings || w_orad - w_ring < 0)
                    fin = 1'b1;
                else
                    prime_walk(w_orad - w_ring);
            end
        end
        iter_out[n-1].last = 1'b1;
        if (fin)
        begin
            iter_out[n-1].done = 1'b1;
            w_busy = 1'b0;
        end
    endtask

    // offer one transaction, wait for it, then predict its results
    task automatic send_item(input logic [1:0] cmd, input logic [IN_W-1:0] d, input bit predict);
        int gap;
        int n;
        bit counts;
        if ((sent_count / 24) % 3 == 2)
            gap = 0;
        else
            gap = $urandom_range(0, 15);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tuser  <= cmd;
        do
            @(posedge clk);
        while (!s_tready);
        sent_count++;
        counts = (cmd == mcr_pkg::CMD_OUTLINE || cmd == mcr_pkg::CMD_FILL)
                 || (cmd == mcr_pkg::CMD_STEP && w_busy);
        if (counts)
            work_count++;
        walk_circle(cmd, d, n);
        if (predict)
            for (int k = 0; k < n; k++)
                pending_spans.push_back(iter_out[k]);
    endtask

    task automatic add_row(input logic [1:0] cmd, input int cx, input int cy, input int rad,
                           input int thick, input bit ink, input bit typed, input int n_typed,
                           input bit done_typed);
        plan_row_t p;
        p.cmd        = cmd;
        p.cx         = cx;
        p.cy         = cy;
        p.rad        = rad;
        p.thick      = thick;
        p.ink        = ink;
        p.typed      = typed;
        p.n_typed    = n_typed;
        p.done_typed = done_typed;
        plan.push_back(p);
    endtask

    // result side: random stalls, one long hold-off, check against the oldest expectation
    initial
    begin : result_side
        int    stall;
        span_t got;
        span_t want;
        m_tready = 1'b0;
        rx_count = 0;
        errors   = 0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (rx_count == HOLD_AT)
                stall = HOLD_OFF;
            else if ((rx_count / 40) % 3 == 1)
                stall = 0;
            else
                stall = $urandom_range(0, 15);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            rx_count++;
            got.xs   = m_tdata[12:0];
            got.ys   = m_tdata[25:13];
            got.xe   = m_tdata[38:26];
            got.ye   = m_tdata[51:39];
            got.ink  = m_tdata[52];
            got.last = m_tlast;
            got.done = m_tuser;
            if (pending_spans.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: x %0d..%0d y %0d..%0d ink %0d last %0d done %0d",
                             got.xs, got.xe, got.ys, got.ye, got.ink, got.last, got.done);
            end
            else
            begin
                want = pending_spans.pop_front();
                if (got !== want)
                begin
                    errors++;
                    if (errors <= 10)
                    begin
                        $display("mismatch on result %0d", rx_count);
                        $display("  expected x %0d..%0d y %0d..%0d ink %0d last %0d done %0d",
                                 want.xs, want.xe, want.ys, want.ye, want.ink, want.last,
                                 want.done);
                        $display("  actual   x %0d..%0d y %0d..%0d ink %0d last %0d done %0d",
                                 got.xs, got.xe, got.ys, got.ye, got.ink, got.last, got.done);
                    end
                end
            end
        end
    end

    // no transaction on either side for too long ends the run
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
                $display("FAIL midpoint_circle_rasterizer");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        plan_row_t p;
        span_t     s;
        int        cx;
        int        cy;
        int        rad;
        int        thick;
        int        cap;
        int        steps;
        bit        ink;
        logic [1:0] cmd;
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = '0;
        sent_count = 0;
        work_count = 0;
        w_busy  = 0; w_fill = 0; w_ccol = 0; w_crow = 0; w_orad = 0;
        w_rings = 0; w_ring = 0; w_x = 0; w_y = 0; w_dec = 0; w_ink = 0;

        // step while idle after reset, reserved code
        add_row(mcr_pkg::CMD_STEP,        0,     0,    0,   0, 0, 1, 0, 0);
        add_row(CMD_RSVD,                 0,     0,    0,   0, 0, 1, 0, 0);
        // zero radius outline: eight pixels on the centre
        add_row(mcr_pkg::CMD_OUTLINE,     0,     0,    0,   1, 1, 1, 0, 0);
        add_row(mcr_pkg::CMD_STEP,        0,     0,    0,   0, 1, 1, 8, 1);
        add_row(mcr_pkg::CMD_STEP,        0,     0,    0,   0, 0, 1, 0, 0);
        // zero radius disc in a corner: four one-pixel spans
        add_row(mcr_pkg::CMD_FILL,    -2048,  2047,    0,   9, 0, 1, 0, 0);
        add_row(mcr_pkg::CMD_STEP,    -2048,  2047,    0,   0, 0, 1, 4, 1);
        // zero thickness leaves the block idle
        add_row(mcr_pkg::CMD_OUTLINE,     5,    -3,    3,   0, 1, 1, 0, 0);
        add_row(mcr_pkg::CMD_STEP,        0,     0,    0,   0, 0, 1, 0, 0);
        // more rings than radius: the shape stops once ring radius would drop below zero
        add_row(mcr_pkg::CMD_OUTLINE,  2047, -2048,    2,   5, 1, 0, 0, 0);
        repeat (5) add_row(mcr_pkg::CMD_STEP, 0, 0, 0, 0, 0, 0, 0, 0);
        // widest shapes at the coordinate extremes, cut short by a restart
        add_row(mcr_pkg::CMD_FILL,    -2048, -2048, 1023, 255, 1, 0, 0, 0);
        repeat (3) add_row(mcr_pkg::CMD_STEP, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(mcr_pkg::CMD_OUTLINE,  2047,  2047, 1023, 255, 0, 0, 0, 0);
        repeat (3) add_row(mcr_pkg::CMD_STEP, 0, 0, 0, 0, 0, 0, 0, 0);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            p = plan[i];
            send_item(p.cmd, pack_shape(p.cx, p.cy, p.rad, p.thick, p.ink), !p.typed);
            for (int k = 0; k < p.n_typed; k++)
            begin
                s.xs   = p.cx[12:0];
                s.ys   = p.cy[12:0];
                s.xe   = p.cx[12:0];
                s.ye   = p.cy[12:0];
                s.ink  = p.ink;
                s.last = (k == p.n_typed - 1);
                s.done = (k == p.n_typed - 1) && p.done_typed;
                pending_spans.push_back(s);
            end
        end

        // random shapes, mostly run to completion, some cut short, some noise
        while (work_count < WORK_ITEMS)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                cmd = $urandom_range(0, 1) ? CMD_RSVD : mcr_pkg::CMD_STEP;
                send_item(cmd, IN_W'({$urandom, $urandom}), 1'b1);
            end
            else
            begin
                cmd   = $urandom_range(0, 1) ? mcr_pkg::CMD_FILL : mcr_pkg::CMD_OUTLINE;
                cx    = $urandom_range(0, 4095) - 2048;
                cy    = $urandom_range(0, 4095) - 2048;
                rad   = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023)
                                                    : $urandom_range(0, 12);
                thick = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 255)
                                                    : $urandom_range(1, 4);
                ink   = $urandom_range(0, 1);
                send_item(cmd, pack_shape(cx, cy, rad, thick, ink), 1'b1);
                if (rad > 16)
                    cap = $urandom_range(1, 5);
                else if ($urandom_range(0, 7) == 0)
                    cap = $urandom_range(0, 3);
                else
                    cap = 100000;
                steps = 0;
                while (w_busy && steps < cap)
                begin
                    send_item(mcr_pkg::CMD_STEP, IN_W'({$urandom, $urandom}), 1'b1);
                    steps++;
                end
            end
        end
        s_tvalid <= 1'b0;

        while (pending_spans.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (errors == 0 && pending_spans.size() == 0)
            $display("PASS midpoint_circle_rasterizer");
        else
            $display("FAIL midpoint_circle_rasterizer");
        $finish;
    end

endmodule

>>> midpoint_circle_rasterizer.f
+incdir+design
design/mcr_pkg.sv
design/mcr_front.sv
design/mcr_queue.sv
design/mcr_back.sv
design/midpoint_circle_rasterizer.sv
tb/sv/midpoint_circle_rasterizer_tb.sv
